FILE: src/swng_pkg.sv
// Package for the square wave note generator: constants, widths, codes
// and the transaction payload types shared by the interfaces and the core.
// No dependencies.
package swng_pkg;

	localparam int AUDIO_FS      = 44100;
	localparam int AMPLITUDE_MAX = 12000;

	localparam int MS_PER_S      = 1000;
	localparam int PERCENT_FULL  = 100;
	localparam int VOLUME_RESET  = 75;
	localparam int HALF_MIN      = 2;

	localparam int VOL_W   = 7;
	localparam int FREQ_W  = 16;
	localparam int MS_W    = 16;
	localparam int SMP_W   = 15;
	localparam int HP_W    = 15;
	localparam int PH_W    = 16;
	localparam int SL_W    = 22;

	localparam int RATE_W     = $clog2(AUDIO_FS + 1);
	localparam int AMPMAX_W   = $clog2(AMPLITUDE_MAX + 1);
	localparam int NOTE_PROD_W = RATE_W + MS_W;
	localparam int AMP_PROD_W  = AMPMAX_W + VOL_W;
	localparam int DIVD_W = (NOTE_PROD_W > AMP_PROD_W) ? NOTE_PROD_W : AMP_PROD_W;
	localparam int CNT_W  = $clog2(DIVD_W + 1);
	localparam int MPL_W  = MS_W;

	localparam logic [SMP_W-1:0] AMP_RESET = SMP_W'(AMPLITUDE_MAX * VOLUME_RESET / PERCENT_FULL);

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef struct packed {
		logic                mode;
		logic [FREQ_W-1:0]   note_freq;
		logic [MS_W-1:0]     note_length_ms;
	} cmd_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last_of_note;
	} audio_item_t;

endpackage

FILE: src/swng_if.sv
// Valid/ready channel interfaces for note commands and audio samples.
// Depends on swng_pkg for the payload types.
interface swng_cmd_if;
	logic                valid;
	logic                ready;
	swng_pkg::cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface swng_audio_if;
	logic                  valid;
	logic                  ready;
	swng_pkg::audio_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/square_wave_note_generator.sv
// Square wave note generator, top level and core.
// Depends on swng_pkg and the channel interfaces in swng_if.sv.
//
// After a load transaction (mode 0) is accepted, cmd stays not ready
// while the multiplier and divider run: one shift-add multiplier step
// per cycle over the 16 bits of note_length_ms, then one restoring
// division bit per cycle for the sample count (by 1000) and, for a tone
// only, for the half period (rate by frequency). A volume write keeps cmd
// not ready while the amplitude is rescaled in the same units. A tick
// transaction (mode 1) is accepted back to back while the core is idle,
// no volume write is pending and the audio output register is free or
// being emptied; for an active note the sample is ready the cycle after.
module square_wave_note_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	swng_cmd_if.sink                      cmd,
	swng_audio_if.source                  audio,
	input  logic                          volume_we,
	input  logic [swng_pkg::VOL_W-1:0]    volume_wdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_HALF = 4'b1000
	} state_t;

	state_t state_q;

	logic [swng_pkg::VOL_W-1:0]   vol_q;
	logic                         amp_pend_q;
	logic                         op_amp_q;
	logic [swng_pkg::SMP_W-1:0]   amp_q;

	logic [swng_pkg::HP_W-1:0]    half_q;
	logic [swng_pkg::PH_W-1:0]    phase_q;
	logic [swng_pkg::SL_W-1:0]    left_q;
	logic                         is_rest_q;
	logic                         active_q;

	logic [swng_pkg::CNT_W-1:0]   cnt_q;
	logic [swng_pkg::DIVD_W-1:0]  acc_q;
	logic [swng_pkg::MPL_W-1:0]   mpl_q;
	logic [swng_pkg::DIVD_W-1:0]  dvd_q;
	logic [swng_pkg::FREQ_W-1:0]  rem_q;
	logic [swng_pkg::FREQ_W-1:0]  div_q;
	logic [swng_pkg::FREQ_W-1:0]  freq_q;

	logic                         out_valid_q;
	swng_pkg::audio_item_t        out_data_q;

	logic                         cmd_fire;
	logic                         tick;
	logic                         load;
	logic                         amp_start;
	logic [swng_pkg::DIVD_W-1:0]  mcand;
	logic [swng_pkg::DIVD_W-1:0]  acc_n;
	logic [swng_pkg::FREQ_W:0]    trial;
	logic                         ge;
	logic [swng_pkg::FREQ_W-1:0]  rem_n;
	logic [swng_pkg::DIVD_W-1:0]  dvd_n;
	logic                         mul_end;
	logic                         div_end;
	logic [swng_pkg::DIVD_W-2:0]  half_full;
	logic [swng_pkg::HP_W-1:0]    half_n;
	logic [swng_pkg::SL_W-1:0]    total_n;
	logic [swng_pkg::PH_W-1:0]    phase_inc;
	logic [swng_pkg::PH_W-1:0]    phase_n;
	logic [swng_pkg::SL_W-1:0]    left_n;
	logic [swng_pkg::SMP_W-1:0]   sample_n;
	logic [swng_pkg::VOL_W-1:0]   vol_sat;

	assign cmd.ready   = (state_q == S_IDLE) && !amp_pend_q && (!out_valid_q || audio.ready);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign tick        = cmd_fire && (cmd.data.mode == swng_pkg::MODE_TICK);
	assign load        = cmd_fire && (cmd.data.mode == swng_pkg::MODE_LOAD);
	assign amp_start   = (state_q == S_IDLE) && amp_pend_q;

	assign audio.valid = out_valid_q;
	assign audio.data  = out_data_q;

	assign vol_sat = (volume_wdata > swng_pkg::VOL_W'(swng_pkg::PERCENT_FULL))
		? swng_pkg::VOL_W'(swng_pkg::PERCENT_FULL) : volume_wdata;

	// shift-add multiply, msb first
	assign mcand = op_amp_q ? swng_pkg::DIVD_W'(swng_pkg::AMPLITUDE_MAX)
		: swng_pkg::DIVD_W'(swng_pkg::AUDIO_FS);
	assign acc_n = {acc_q[swng_pkg::DIVD_W-2:0], 1'b0}
		+ (mpl_q[swng_pkg::MPL_W-1] ? mcand : '0);

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[swng_pkg::DIVD_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign rem_n = ge ? swng_pkg::FREQ_W'(trial - {1'b0, div_q}) : trial[swng_pkg::FREQ_W-1:0];
	assign dvd_n = {dvd_q[swng_pkg::DIVD_W-2:0], ge};

	assign mul_end = (cnt_q == swng_pkg::CNT_W'(swng_pkg::MPL_W - 1));
	assign div_end = (cnt_q == swng_pkg::CNT_W'(swng_pkg::DIVD_W - 1));

	always_comb begin
		total_n = |dvd_n[swng_pkg::DIVD_W-1:swng_pkg::SL_W] ? '1 : dvd_n[swng_pkg::SL_W-1:0];
		half_full = dvd_n[swng_pkg::DIVD_W-1:1];
		if (|half_full[swng_pkg::DIVD_W-2:swng_pkg::HP_W]) begin
			half_n = '1;
		end else if (half_full[swng_pkg::HP_W-1:0] < swng_pkg::HP_W'(swng_pkg::HALF_MIN)) begin
			half_n = swng_pkg::HP_W'(swng_pkg::HALF_MIN);
		end else begin
			half_n = half_full[swng_pkg::HP_W-1:0];
		end
	end

	always_comb begin
		phase_inc = phase_q + 1'b1;
		phase_n   = (phase_inc >= {half_q, 1'b0}) ? '0 : phase_inc;
		left_n    = (left_q != '0) ? left_q - 1'b1 : left_q;
		if (is_rest_q) begin
			sample_n = '0;
		end else if (phase_q < {1'b0, half_q}) begin
			sample_n = amp_q;
		end else begin
			sample_n = swng_pkg::SMP_W'(-amp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vol_q       <= swng_pkg::VOL_W'(swng_pkg::VOLUME_RESET);
			amp_pend_q  <= 1'b0;
			op_amp_q    <= 1'b0;
			amp_q       <= swng_pkg::AMP_RESET;
			half_q      <= '0;
			phase_q     <= '0;
			left_q      <= '0;
			is_rest_q   <= 1'b0;
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (volume_we) begin
				vol_q      <= vol_sat;
				amp_pend_q <= 1'b1;
			end else if (amp_start) begin
				amp_pend_q <= 1'b0;
			end

			if (tick && active_q) begin
				out_valid_q <= 1'b1;
			end else if (audio.ready) begin
				out_valid_q <= 1'b0;
			end

			if (tick && active_q) begin
				left_q   <= left_n;
				active_q <= (left_n != '0);
				if (!is_rest_q) begin
					phase_q <= phase_n;
				end
			end

			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (amp_start) begin
						op_amp_q <= 1'b1;
						state_q  <= S_MUL;
					end else if (load) begin
						op_amp_q <= 1'b0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q <= mul_end ? '0 : cnt_q + 1'b1;
					if (mul_end) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= div_end ? '0 : cnt_q + 1'b1;
					if (div_end) begin
						if (op_amp_q) begin
							amp_q   <= dvd_n[swng_pkg::SMP_W-1:0];
							state_q <= S_IDLE;
						end else begin
							left_q    <= total_n;
							active_q  <= (total_n != '0);
							phase_q   <= '0;
							is_rest_q <= (freq_q == '0);
							if (freq_q == '0) begin
								half_q  <= '0;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_HALF;
							end
						end
					end
				end
				S_HALF: begin
					cnt_q <= div_end ? '0 : cnt_q + 1'b1;
					if (div_end) begin
						half_q  <= half_n;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (tick && active_q) begin
			out_data_q.sample       <= sample_n;
			out_data_q.last_of_note <= (left_n == '0);
		end
		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				if (amp_start) begin
					mpl_q <= swng_pkg::MPL_W'(vol_q);
				end else if (load) begin
					mpl_q  <= cmd.data.note_length_ms;
					freq_q <= cmd.data.note_freq;
				end
			end
			S_MUL: begin
				acc_q <= acc_n;
				mpl_q <= {mpl_q[swng_pkg::MPL_W-2:0], 1'b0};
				if (mul_end) begin
					dvd_q <= acc_n;
					rem_q <= '0;
					div_q <= op_amp_q ? swng_pkg::FREQ_W'(swng_pkg::PERCENT_FULL)
						: swng_pkg::FREQ_W'(swng_pkg::MS_PER_S);
				end
			end
			S_DIV: begin
				if (div_end) begin
					dvd_q <= swng_pkg::DIVD_W'(swng_pkg::AUDIO_FS);
					rem_q <= '0;
					div_q <= freq_q;
				end else begin
					dvd_q <= dvd_n;
					rem_q <= rem_n;
				end
			end
			S_HALF: begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.ready)
		else $error("cmd ready while divider busy");

	a_half_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && active_q && !is_rest_q)
			|-> (half_q >= swng_pkg::HP_W'(swng_pkg::HALF_MIN)))
		else $error("active tone with half period below minimum");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && active_q && !is_rest_q) |-> (phase_q < {half_q, 1'b0}))
		else $error("phase outside period");

	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q <= swng_pkg::SMP_W'(swng_pkg::AMPLITUDE_MAX))
		else $error("amplitude above maximum");

	a_last_ends_note: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && active_q && left_n == '0) |=> !active_q)
		else $error("note still active after last sample");
`endif

endmodule
